>>> rtl/core/clp_pkg.sv
`timescale 1ns / 1ps

package clp_pkg;

    // Default sizing of the parser.
    localparam int MAX_DATA_DEF        = 8;
    localparam int FRACTION_DIGITS_DEF = 6;
    localparam int QUEUE_DEPTH         = 2;

    // Field widths.
    localparam int SEC_W   = 34;
    localparam int FRAC_W  = 20;
    localparam int FDIG_W  = 3;
    localparam int ID_W    = 29;
    localparam int CNT_W   = 4;
    localparam int DATA_W  = 64;
    localparam int TS_W    = 53;
    localparam int STAT_W  = 2;

    // Status codes.
    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_BAD     = 2'd1;
    localparam logic [STAT_W-1:0] ST_OVER    = 2'd2;
    localparam logic [STAT_W-1:0] ST_MISSING = 2'd3;

    // One character of a log line.
    typedef struct packed {
        logic [7:0] character;
        logic       line_end;
    } char_item_t;

    // One parsed line.
    typedef struct packed {
        logic [TS_W-1:0]   timestamp_us;
        logic [ID_W-1:0]   frame_id;
        logic [CNT_W-1:0]  byte_count;
        logic [DATA_W-1:0] data_bytes;
        logic [STAT_W-1:0] status;
    } result_item_t;

    // Raw line fields handed from the parser to the timestamp back end.
    typedef struct packed {
        logic [SEC_W-1:0]  seconds;
        logic [FRAC_W-1:0] fraction;
        logic [FDIG_W-1:0] fraction_digits;
        logic [ID_W-1:0]   frame_id;
        logic [CNT_W-1:0]  byte_count;
        logic [DATA_W-1:0] data_bytes;
        logic [STAT_W-1:0] status;
    } line_rec_t;

endpackage

>>> rtl/core/can_log_line_parser.sv
// Channel   Direction  Payload                  Handshake
// char      in         clp_pkg::char_item_t     char_valid / char_ready
// result    out        clp_pkg::result_item_t   result_valid / result_ready
//
// One character is taken per cycle while the line queue has room; the parser updates its
// line state in that cycle. A line's result passes the line queue, the register after the
// seconds and fraction multipliers, and the result register after the add and saturation.
// Reset clears the line state, the two-entry line queue and the stage valid flags.
// A stalled result holds the back end; characters keep flowing until the queue fills.
`timescale 1ns / 1ps

module can_log_line_parser #(
    parameter int MAX_DATA        = clp_pkg::MAX_DATA_DEF,
    parameter int FRACTION_DIGITS = clp_pkg::FRACTION_DIGITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   char_valid,
    output logic                   char_ready,
    input  clp_pkg::char_item_t    char_data,
    output logic                   result_valid,
    input  logic                   result_ready,
    output clp_pkg::result_item_t  result_data
);

    logic                room;
    logic                push;
    clp_pkg::line_rec_t  push_rec;
    logic                pop;
    logic                head_valid;
    clp_pkg::line_rec_t  head_rec;

    // Character parser.
    clp_front #(
        .MAX_DATA        (MAX_DATA),
        .FRACTION_DIGITS (FRACTION_DIGITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_valid),
        .char_ready (char_ready),
        .char_data  (char_data),
        .room       (room),
        .push       (push),
        .rec        (push_rec)
    );

    // Line queue between parser and back end.
    clp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_rec   (push_rec),
        .room       (room),
        .pop        (pop),
        .head_valid (head_valid),
        .head_rec   (head_rec)
    );

    // Timestamp arithmetic and result register.
    clp_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head_rec     (head_rec),
        .pop          (pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_data  (result_data)
    );

endmodule

>>> rtl/core/clp_front.sv
`timescale 1ns / 1ps

module clp_front #(
    parameter int MAX_DATA        = clp_pkg::MAX_DATA_DEF,
    parameter int FRACTION_DIGITS = clp_pkg::FRACTION_DIGITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  char_valid,
    output logic                  char_ready,
    input  clp_pkg::char_item_t   char_data,
    input  logic                  room,
    output logic                  push,
    output clp_pkg::line_rec_t    rec
);

    localparam logic [2:0] PH_START    = 3'd0;
    localparam logic [2:0] PH_SECONDS  = 3'd1;
    localparam logic [2:0] PH_FRACTION = 3'd2;
    localparam logic [2:0] PH_GAP      = 3'd3;
    localparam logic [2:0] PH_IFACE    = 3'd4;
    localparam logic [2:0] PH_ID       = 3'd5;
    localparam logic [2:0] PH_DATA     = 3'd6;

    localparam logic [clp_pkg::SEC_W-1:0] SEC_MAX = {clp_pkg::SEC_W{1'b1}};
    localparam logic [clp_pkg::ID_W-1:0]  ID_MAX  = {clp_pkg::ID_W{1'b1}};
    localparam logic [clp_pkg::CNT_W-1:0] MAX_BYTES = clp_pkg::CNT_W'(MAX_DATA);
    localparam logic [clp_pkg::FDIG_W-1:0] MAX_FDIG = clp_pkg::FDIG_W'(FRACTION_DIGITS);

    logic [2:0]                    phase_reg, phase_next;
    logic [clp_pkg::SEC_W-1:0]     sec_reg, sec_next;
    logic [clp_pkg::FRAC_W-1:0]    frac_reg, frac_next;
    logic [clp_pkg::FDIG_W-1:0]    fdig_reg, fdig_next;
    logic [clp_pkg::ID_W-1:0]      id_reg, id_next;
    logic [4:0]                    nib_reg, nib_next;
    logic [clp_pkg::CNT_W-1:0]     cnt_reg, cnt_next;
    logic [clp_pkg::DATA_W-1:0]    data_reg, data_next;
    logic [clp_pkg::STAT_W-1:0]    err_reg, err_next;
    logic                          seen_reg, seen_next;

    logic [7:0]  c;
    logic        accept;
    logic        blank;
    logic        is_digit;
    logic [3:0]  dval;
    logic        is_hex;
    logic [3:0]  hval;
    logic [clp_pkg::SEC_W+3:0]  sec_x10;
    logic [clp_pkg::ID_W+3:0]   id_x16;
    logic [clp_pkg::FRAC_W-1:0] frac_x10;
    logic [7:0]  new_byte;

    assign char_ready = room;
    assign accept     = char_valid && room;
    assign c          = char_data.character;

    // Character classes.
    always_comb
    begin
        blank    = (c == 8'h20) || (c == 8'h09) || (c == 8'h0A) || (c == 8'h0D);
        is_digit = (c >= 8'h30) && (c <= 8'h39);
        dval     = 4'(c - 8'h30);
        is_hex   = 1'b1;
        hval     = dval;
        if (is_digit)
        begin
            hval = dval;
        end
        else if ((c >= 8'h61) && (c <= 8'h66))
        begin
            hval = 4'(c - 8'h57);
        end
        else if ((c >= 8'h41) && (c <= 8'h46))
        begin
            hval = 4'(c - 8'h37);
        end
        else
        begin
            is_hex = 1'b0;
        end
    end

    // Digit accumulation with overflow detection.
    assign sec_x10  = ({4'd0, sec_reg} << 3) + ({4'd0, sec_reg} << 1)
                      + {{(clp_pkg::SEC_W){1'b0}}, dval};
    assign id_x16   = {id_reg, 4'd0} + {{(clp_pkg::ID_W){1'b0}}, hval};
    assign frac_x10 = (frac_reg << 3) + (frac_reg << 1) + {{(clp_pkg::FRAC_W-4){1'b0}}, dval};
    assign new_byte = {nib_reg[3:0], hval};

    // Parser state machine; the whole line state clears after its last character.
    always_comb
    begin
        phase_next = phase_reg;
        sec_next   = sec_reg;
        frac_next  = frac_reg;
        fdig_next  = fdig_reg;
        id_next    = id_reg;
        nib_next   = nib_reg;
        cnt_next   = cnt_reg;
        data_next  = data_reg;
        err_next   = err_reg;
        seen_next  = seen_reg;
        push       = 1'b0;
        rec        = '0;

        if (accept && (err_reg == clp_pkg::ST_OK))
        begin
            if (phase_reg == PH_IFACE)
            begin
                if (blank)
                begin
                    phase_next = PH_ID;
                    seen_next  = 1'b0;
                end
            end
            else if (!blank)
            begin
                case (phase_reg)
                    PH_START:
                    begin
                        if (c == 8'h28)
                        begin
                            phase_next = PH_SECONDS;
                            seen_next  = 1'b0;
                        end
                        else
                        begin
                            err_next = clp_pkg::ST_BAD;
                        end
                    end
                    PH_SECONDS, PH_FRACTION:
                    begin
                        if (is_digit)
                        begin
                            seen_next = 1'b1;
                            if (phase_reg == PH_SECONDS)
                            begin
                                if (sec_x10 > {4'd0, SEC_MAX})
                                begin
                                    sec_next = SEC_MAX;
                                end
                                else
                                begin
                                    sec_next = sec_x10[clp_pkg::SEC_W-1:0];
                                end
                            end
                            else if (fdig_reg < MAX_FDIG)
                            begin
                                frac_next = frac_x10;
                                fdig_next = fdig_reg + 3'd1;
                            end
                        end
                        else if ((c == 8'h2E) && (phase_reg == PH_SECONDS))
                        begin
                            phase_next = PH_FRACTION;
                        end
                        else if (c == 8'h29)
                        begin
                            if (!seen_reg)
                            begin
                                err_next = clp_pkg::ST_MISSING;
                            end
                            else
                            begin
                                phase_next = PH_GAP;
                            end
                        end
                        else
                        begin
                            err_next = clp_pkg::ST_BAD;
                        end
                    end
                    PH_GAP:
                    begin
                        phase_next = PH_IFACE;
                    end
                    PH_ID:
                    begin
                        if (is_hex)
                        begin
                            seen_next = 1'b1;
                            if (id_x16 > {4'd0, ID_MAX})
                            begin
                                id_next = ID_MAX;
                            end
                            else
                            begin
                                id_next = id_x16[clp_pkg::ID_W-1:0];
                            end
                        end
                        else if (c == 8'h23)
                        begin
                            if (!seen_reg)
                            begin
                                err_next = clp_pkg::ST_MISSING;
                            end
                            else
                            begin
                                phase_next = PH_DATA;
                                nib_next   = 5'd0;
                            end
                        end
                        else
                        begin
                            err_next = clp_pkg::ST_BAD;
                        end
                    end
                    PH_DATA:
                    begin
                        if (!is_hex)
                        begin
                            err_next = clp_pkg::ST_BAD;
                        end
                        else if (!nib_reg[4])
                        begin
                            nib_next = {1'b1, hval};
                        end
                        else
                        begin
                            nib_next = 5'd0;
                            if (cnt_reg >= MAX_BYTES)
                            begin
                                err_next = clp_pkg::ST_OVER;
                            end
                            else
                            begin
                                data_next[8*cnt_reg[2:0] +: 8] =
                                    data_reg[8*cnt_reg[2:0] +: 8] | new_byte;
                                cnt_next = cnt_reg + 4'd1;
                            end
                        end
                    end
                    default:
                    begin
                        err_next = clp_pkg::ST_BAD;
                    end
                endcase
            end
        end

        // Hand the finished line to the back end and start over.
        if (accept && char_data.line_end)
        begin
            push                = 1'b1;
            rec.seconds         = sec_next;
            rec.fraction        = frac_next;
            rec.fraction_digits = fdig_next;
            rec.frame_id        = id_next;
            rec.byte_count      = cnt_next;
            rec.data_bytes      = data_next;
            if (err_next != clp_pkg::ST_OK)
            begin
                rec.status = err_next;
            end
            else if (phase_next != PH_DATA)
            begin
                rec.status = clp_pkg::ST_MISSING;
            end
            else
            begin
                rec.status = clp_pkg::ST_OK;
            end
            phase_next = PH_START;
            sec_next   = '0;
            frac_next  = '0;
            fdig_next  = '0;
            id_next    = '0;
            nib_next   = '0;
            cnt_next   = '0;
            data_next  = '0;
            err_next   = clp_pkg::ST_OK;
            seen_next  = 1'b0;
        end
    end

    // Line state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_START;
            sec_reg   <= '0;
            frac_reg  <= '0;
            fdig_reg  <= '0;
            id_reg    <= '0;
            nib_reg   <= '0;
            cnt_reg   <= '0;
            data_reg  <= '0;
            err_reg   <= clp_pkg::ST_OK;
            seen_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            sec_reg   <= sec_next;
            frac_reg  <= frac_next;
            fdig_reg  <= fdig_next;
            id_reg    <= id_next;
            nib_reg   <= nib_next;
            cnt_reg   <= cnt_next;
            data_reg  <= data_next;
            err_reg   <= err_next;
            seen_reg  <= seen_next;
        end
    end

endmodule

>>> rtl/core/clp_queue.sv
`timescale 1ns / 1ps

module clp_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  clp_pkg::line_rec_t  push_rec,
    output logic                room,
    input  logic                pop,
    output logic                head_valid,
    output clp_pkg::line_rec_t  head_rec
);

    localparam int DEPTH = clp_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL = CNT_W'(DEPTH);

    clp_pkg::line_rec_t  entry_reg [DEPTH];
    logic [PTR_W-1:0]    wr_reg, wr_next;
    logic [PTR_W-1:0]    rd_reg, rd_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                do_push;
    logic                do_pop;

    assign room       = (cnt_reg != FULL);
    assign head_valid = (cnt_reg != '0);
    assign head_rec   = entry_reg[rd_reg];
    assign do_push    = push && room;
    assign do_pop     = pop && head_valid;

    // Pointer and fill count update.
    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (do_push)
        begin
            wr_next = (wr_reg == LAST) ? '0 : wr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_next = (rd_reg == LAST) ? '0 : rd_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_reg] <= push_rec;
        end
    end

endmodule

>>> rtl/core/clp_back.sv
`timescale 1ns / 1ps

module clp_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   head_valid,
    input  clp_pkg::line_rec_t     head_rec,
    output logic                   pop,
    output logic                   result_valid,
    input  logic                   result_ready,
    output clp_pkg::result_item_t  result_data
);

    localparam int MUL_W = clp_pkg::SEC_W + 14;
    localparam int SUM_W = MUL_W + 7;
    localparam logic [clp_pkg::SEC_W-1:0] SEC_LIMIT = 34'd9007199254;
    localparam logic [SUM_W-1:0] TS_MAX = SUM_W'({clp_pkg::TS_W{1'b1}});

    // Scale for a fraction of the given digit count, in microseconds.
    function automatic logic [clp_pkg::FRAC_W-1:0] frac_scale(
        input logic [clp_pkg::FDIG_W-1:0] digits);
        logic [clp_pkg::FRAC_W-1:0] s;
        begin
            case (digits)
                3'd0:    s = 20'd1000000;
                3'd1:    s = 20'd100000;
                3'd2:    s = 20'd10000;
                3'd3:    s = 20'd1000;
                3'd4:    s = 20'd100;
                3'd5:    s = 20'd10;
                default: s = 20'd1;
            endcase
            frac_scale = s;
        end
    endfunction

    logic                        s1_valid_reg;
    logic [MUL_W-1:0]            s1_sec_mul_reg;
    logic [clp_pkg::FRAC_W-1:0]  s1_frac_us_reg;
    logic                        s1_big_reg;
    clp_pkg::line_rec_t          s1_rec_reg;
    logic                        out_valid_reg;
    clp_pkg::result_item_t       out_reg, out_next;

    logic                        adv_out;
    logic                        adv_s1;
    logic [MUL_W-1:0]            sec_mul;
    logic [2*clp_pkg::FRAC_W-1:0] frac_mul;
    logic [SUM_W-1:0]            ts_sum;

    assign adv_out      = !out_valid_reg || result_ready;
    assign adv_s1       = !s1_valid_reg || adv_out;
    assign pop          = head_valid && adv_s1;
    assign result_valid = out_valid_reg;
    assign result_data  = out_reg;

    // Stage one: seconds times 15625 (the shift by six follows) and fraction scaling.
    assign sec_mul  = MUL_W'(head_rec.seconds) * MUL_W'(14'd15625);
    assign frac_mul = head_rec.fraction * frac_scale(head_rec.fraction_digits);

    always_ff @(posedge clk)
    begin
        if (adv_s1)
        begin
            s1_sec_mul_reg <= sec_mul;
            s1_frac_us_reg <= frac_mul[clp_pkg::FRAC_W-1:0];
            s1_big_reg     <= (head_rec.seconds > SEC_LIMIT);
            s1_rec_reg     <= head_rec;
        end
    end

    // Stage two: add, saturate, and clear the fields of a failed line.
    assign ts_sum = {1'b0, s1_sec_mul_reg, 6'd0} + SUM_W'(s1_frac_us_reg);

    always_comb
    begin
        out_next = '0;
        out_next.status = s1_rec_reg.status;
        if (s1_rec_reg.status == clp_pkg::ST_OK)
        begin
            if (s1_big_reg || (ts_sum > TS_MAX))
            begin
                out_next.timestamp_us = {clp_pkg::TS_W{1'b1}};
            end
            else
            begin
                out_next.timestamp_us = ts_sum[clp_pkg::TS_W-1:0];
            end
            out_next.frame_id   = s1_rec_reg.frame_id;
            out_next.byte_count = s1_rec_reg.byte_count;
            out_next.data_bytes = s1_rec_reg.data_bytes;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv_out)
        begin
            out_reg <= out_next;
        end
    end

    // Valid flags of both stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv_s1)
            begin
                s1_valid_reg <= head_valid;
            end
            if (adv_out)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

endmodule

>>> bench/can_log_line_parser_tb.sv
`timescale 1ns / 1ps

module can_log_line_parser_tb;

    // Phases of a log line as the predictor walks through it.
    typedef enum logic [2:0] {
        LP_OPEN,
        LP_SECONDS,
        LP_FRACTION,
        LP_GAP,
        LP_IFACE,
        LP_ID,
        LP_DATA
    } line_phase_e;

    localparam longint unsigned SEC_LIMIT = 64'h3_FFFF_FFFF;
    localparam longint unsigned TS_LIMIT  = 64'h1F_FFFF_FFFF_FFFF;
    localparam longint unsigned ID_LIMIT  = 64'h1FFF_FFFF;
    localparam int              HOLD_CYCLES = 300;

    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  char_valid   = 1'b0;
    clp_pkg::char_item_t   char_data    = '0;
    logic                  result_ready = 1'b0;
    logic                  char_ready;
    logic                  result_valid;
    clp_pkg::result_item_t result_data;

    // Predictor copy of the line state.
    line_phase_e  lp;
    logic [33:0]  sec_sum;
    logic [19:0]  frac_sum;
    logic [2:0]   frac_cnt;
    logic [28:0]  id_sum;
    logic [4:0]   half_byte;
    logic [3:0]   byte_cnt;
    logic [63:0]  data_sum;
    logic [1:0]   line_err;
    bit           got_digit;

    clp_pkg::result_item_t pending_lines[$];
    clp_pkg::result_item_t want_line;
    logic [7:0]   line_buf[$];
    int           mismatch_count = 0;
    int           hold_request   = 0;
    bit           no_idle        = 1'b0;

    can_log_line_parser u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .char_valid   (char_valid),
        .char_ready   (char_ready),
        .char_data    (char_data),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_data  (result_data)
    );

    // Clock with a 20 ns period.
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Character classes.
    function automatic int hex_of(logic [7:0] c);
        if (c >= "0" && c <= "9") return c - "0";
        if (c >= "a" && c <= "f") return c - "a" + 10;
        if (c >= "A" && c <= "F") return c - "A" + 10;
        return -1;
    endfunction

    function automatic bit is_space(logic [7:0] c);
        return c == " " || c == "\t" || c == "\n" || c == "\r";
    endfunction

    function void clear_line();
        lp        = LP_OPEN;
        sec_sum   = '0;
        frac_sum  = '0;
        frac_cnt  = '0;
        id_sum    = '0;
        half_byte = '0;
        byte_cnt  = '0;
        data_sum  = '0;
        line_err  = clp_pkg::ST_OK;
        got_digit = 1'b0;
    endfunction

    // Only the first error of a line is kept.
    function void flag(logic [1:0] code);
        if (line_err == clp_pkg::ST_OK) line_err = code;
    endfunction

    // Advance the line state by one character.
    function void parse_char(logic [7:0] c);
        int          h;
        int unsigned d;
        logic [7:0]  b;
        h = hex_of(c);
        // The interface token runs up to the next blank.
        if (lp == LP_IFACE)
        begin
            if (is_space(c))
            begin
                lp = LP_ID;
                got_digit = 1'b0;
            end
            return;
        end
        if (is_space(c)) return;
        case (lp)
            LP_OPEN:
            begin
                if (c == "(")
                begin
                    lp = LP_SECONDS;
                    got_digit = 1'b0;
                end
                else flag(clp_pkg::ST_BAD);
            end
            LP_SECONDS, LP_FRACTION:
            begin
                if (c >= "0" && c <= "9")
                begin
                    d = 32'(c - "0");
                    got_digit = 1'b1;
                    if (lp == LP_SECONDS)
                    begin
                        if (sec_sum > (SEC_LIMIT - d) / 10) sec_sum = '1;
                        else sec_sum = 34'(sec_sum * 10 + d);
                    end
                    else if (frac_cnt < clp_pkg::FRACTION_DIGITS_DEF)
                    begin
                        frac_sum = 20'(frac_sum * 10 + d);
                        frac_cnt++;
                    end
                end
                else if (c == "." && lp == LP_SECONDS) lp = LP_FRACTION;
                else if (c == ")")
                begin
                    if (!got_digit) flag(clp_pkg::ST_MISSING);
                    else lp = LP_GAP;
                end
                else flag(clp_pkg::ST_BAD);
            end
            LP_GAP: lp = LP_IFACE;
            LP_ID:
            begin
                if (h >= 0)
                begin
                    got_digit = 1'b1;
                    if (id_sum > (ID_LIMIT - h) / 16) id_sum = '1;
                    else id_sum = 29'(id_sum * 16 + h);
                end
                else if (c == "#")
                begin
                    if (!got_digit) flag(clp_pkg::ST_MISSING);
                    else
                    begin
                        lp = LP_DATA;
                        half_byte = '0;
                    end
                end
                else flag(clp_pkg::ST_BAD);
            end
            LP_DATA:
            begin
                if (h < 0) flag(clp_pkg::ST_BAD);
                else if (!half_byte[4]) half_byte = {1'b1, h[3:0]};
                else
                begin
                    b = {half_byte[3:0], h[3:0]};
                    half_byte = '0;
                    if (byte_cnt >= clp_pkg::MAX_DATA_DEF) flag(clp_pkg::ST_OVER);
                    else
                    begin
                        data_sum[byte_cnt * 8 +: 8] = b;
                        byte_cnt++;
                    end
                end
            end
            default: flag(clp_pkg::ST_BAD);
        endcase
    endfunction

    // Take one accepted item; at line end queue the parsed line.
    function void log_char(clp_pkg::char_item_t it);
        clp_pkg::result_item_t line;
        logic [1:0]      stat;
        longint unsigned frac_us;
        longint unsigned ts;
        if (line_err == clp_pkg::ST_OK) parse_char(it.character);
        if (it.line_end)
        begin
            stat = line_err;
            if (stat == clp_pkg::ST_OK && lp != LP_DATA) stat = clp_pkg::ST_MISSING;
            line = '0;
            line.status = stat;
            if (stat == clp_pkg::ST_OK)
            begin
                // Scale the kept fraction digits up to microseconds.
                frac_us = 64'(frac_sum);
                for (int k = frac_cnt; k < 6; k++) frac_us = frac_us * 10;
                if (sec_sum > TS_LIMIT / 1000000) ts = TS_LIMIT;
                else
                begin
                    ts = 64'(sec_sum) * 64'd1000000;
                    if (ts > TS_LIMIT - frac_us) ts = TS_LIMIT;
                    else ts = ts + frac_us;
                end
                line.timestamp_us = ts[52:0];
                line.frame_id     = id_sum;
                line.byte_count   = byte_cnt;
                line.data_bytes   = data_sum;
            end
            pending_lines.insert(pending_lines.size(), line);
            clear_line();
        end
    endfunction

    task report_mismatch(input string field, input logic [63:0] got, input logic [63:0] want);
        mismatch_count++;
        $display("mismatch in %s at %0t: got %0h, expected %0h", field, $time, got, want);
    endtask

    // Line building helpers.
    function void add_char(logic [7:0] b);
        line_buf.insert(line_buf.size(), b);
    endfunction

    function void put_text(string s);
        for (int i = 0; i < s.len(); i++) add_char(s[i]);
    endfunction

    function automatic logic [7:0] hex_char(int v);
        if (v < 10) return 8'("0" + v);
        if ($urandom_range(1)) return 8'("a" + v - 10);
        return 8'("A" + v - 10);
    endfunction

    function void put_blanks(int lo, int hi);
        repeat ($urandom_range(hi, lo))
        begin
            case ($urandom_range(7))
                0: add_char("\t");
                1: add_char("\r");
                2: add_char("\n");
                default: add_char(" ");
            endcase
        end
    endfunction

    // A log line with random content, mostly well-formed; some carry odd digits or data overflows.
    function void build_log_line();
        int r;
        int n;
        line_buf.delete();
        if ($urandom_range(9) == 0) put_blanks(1, 2);
        add_char("(");
        r = $urandom_range(99);
        n = (r < 70) ? 10 : (r < 90) ? $urandom_range(1, 6) : $urandom_range(11, 13);
        repeat (n) add_char(8'("0" + $urandom_range(9)));
        if ($urandom_range(9) != 0)
        begin
            add_char(".");
            n = ($urandom_range(99) < 70) ? 6 : $urandom_range(0, 9);
            repeat (n) add_char(8'("0" + $urandom_range(9)));
        end
        if ($urandom_range(9) == 0) put_blanks(1, 1);
        add_char(")");
        put_blanks(0, 2);
        case ($urandom_range(3))
            0: put_text("can0");
            1: put_text("vcan1");
            2: put_text("can1");
            default: repeat ($urandom_range(1, 6)) add_char(8'($urandom_range(33, 255)));
        endcase
        put_blanks(1, 2);
        // Frame id: short ids, full 29-bit ids and overlong ones.
        r = $urandom_range(9);
        if (r < 4) repeat (3) add_char(hex_char($urandom_range(15)));
        else if (r < 8)
        begin
            add_char(hex_char($urandom_range(1)));
            repeat (7) add_char(hex_char($urandom_range(15)));
        end
        else repeat ($urandom_range(1, 10)) add_char(hex_char($urandom_range(15)));
        add_char("#");
        // Data digits: mostly whole bytes, some odd counts and overflows.
        r = $urandom_range(99);
        n = (r < 85) ? 2 * $urandom_range(0, 8) : (r < 95) ? $urandom_range(0, 8) * 2 + 1
            : 2 * $urandom_range(9, 10);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(19) == 0) put_blanks(1, 1);
            add_char(hex_char($urandom_range(15)));
        end
        if ($urandom_range(9) < 3) add_char("\n");
    endfunction

    // Damage a line: overwrite, cut short, insert a byte, or replace with noise.
    function void break_log_line();
        int pos;
        int sel;
        pos = $urandom_range(line_buf.size() - 1);
        sel = $urandom_range(3);
        case (sel)
            0: line_buf[pos] = 8'($urandom_range(255));
            1: while (line_buf.size() > pos + 1) void'(line_buf.pop_back());
            2: line_buf.insert(pos, 8'($urandom_range(255)));
            default:
            begin
                line_buf.delete();
                repeat ($urandom_range(1, 12)) add_char(8'($urandom_range(255)));
            end
        endcase
    endfunction

    // Offer one item and wait until it is taken.
    task send_char(input logic [7:0] c, input logic last);
        if (!no_idle && $urandom_range(99) < 27)
        begin
            char_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        char_valid <= 1'b1;
        char_data  <= '{character: c, line_end: last};
        @(posedge clk);
        while (!char_ready) @(posedge clk);
        log_char('{character: c, line_end: last});
    endtask

    task send_log_line();
        for (int i = 0; i < line_buf.size(); i++)
            send_char(line_buf[i], i == line_buf.size() - 1);
    endtask

    task send_line(input string s);
        line_buf.delete();
        put_text(s);
        send_log_line();
    endtask

    // Well-formed lines, blanks in every phase, odd interface tokens.
    task test_plain_lines();
        send_line("(1436509052.249713) can0 044#2A366C2BBA");
        send_line("(0.000000) vcan0 0#");
        send_line("(7) x 7ff#0011223344556677");
        send_line("\t( 12 . 5 )\tcan0\r 1A #  0a 0B\n");
        send_line("(1)can0 1#");
        send_line("(1) #)( 5#ab\n");
    endtask

    // Fraction truncation and timestamp saturation.
    task test_timestamps();
        send_line("(3.1234567) c 1#");
        send_line("(9007199254.740991) c 1#");
        send_line("(9007199254.740992) c 1#");
        send_line("(9007199255) c 1#");
        send_line("(99999999999999.999999) c 1#");
        send_line("(.5) c 1#");
        send_line("(5.) c 1#");
    endtask

    task test_frame_ids();
        send_line("(1) c 1FFFFFFF#");
        send_line("(1) c 20000000#");
        send_line("(1) c fffffffff#ff");
    endtask

    // Every error code, the first error winning, and trailing odd digits.
    task test_bad_lines();
        send_line("x(1) c 1#");
        send_line("() c 1#");
        send_line("(.) c 1#");
        send_line("(1.2.3) c 1#");
        send_line("(1a) c 1#zz");
        send_line("(1#) c 1#");
        send_line("(1) c #12");
        send_line("(1) c 12G#");
        send_line("(1) c 1)#");
        send_line("(1) c 1#1Z");
        send_line("(1) c 1##");
        send_line("(1) c 1#001122334455667788");
        send_line("(1) c 1#0011223344556677889");
        send_line("(1) c 1#00112233445566778");
        send_line("(1) c 1#123");
        send_line("(1) c 12");
        send_line("(1) can0");
        send_line("(");
        send_line("\n");
        send_line("() c #G");
        line_buf.delete();
        put_text("(1");
        add_char(8'hC8);
        put_text(") c 1#");
        send_log_line();
    endtask

    // Hold the result side off while short lines keep arriving.
    task test_back_pressure();
        no_idle = 1'b1;
        hold_request = HOLD_CYCLES;
        for (int k = 0; k < 30; k++)
            send_line($sformatf("(%0d.%0d) c %0h#%02h", k, k, k, k));
        no_idle = 1'b0;
    endtask

    task test_steady_stream();
        no_idle = 1'b1;
        repeat (8)
        begin
            build_log_line();
            send_log_line();
        end
        no_idle = 1'b0;
    endtask

    task test_random_lines();
        int sent;
        sent = 0;
        while (sent < 360)
        begin
            build_log_line();
            if ($urandom_range(99) < 28) break_log_line();
            sent += line_buf.size();
            send_log_line();
        end
    endtask

    // Result side: random stalls, or a counted hold-off on request.
    initial
    begin
        int n;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_request != 0)
            begin
                n = hold_request;
                hold_request = 0;
                result_ready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            else result_ready <= no_idle || ($urandom_range(99) >= 27);
        end
    end

    // Compare each parsed line with the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_lines.size() == 0)
                report_mismatch("result with none expected", 64'(result_data.status),
                                64'd0);
            else
            begin
                want_line = pending_lines.pop_front();
                if (result_data.timestamp_us !== want_line.timestamp_us)
                    report_mismatch("timestamp_us", 64'(result_data.timestamp_us),
                                    64'(want_line.timestamp_us));
                if (result_data.frame_id !== want_line.frame_id)
                    report_mismatch("frame_id", 64'(result_data.frame_id),
                                    64'(want_line.frame_id));
                if (result_data.byte_count !== want_line.byte_count)
                    report_mismatch("byte_count", 64'(result_data.byte_count),
                                    64'(want_line.byte_count));
                if (result_data.data_bytes !== want_line.data_bytes)
                    report_mismatch("data_bytes", result_data.data_bytes,
                                    want_line.data_bytes);
                if (result_data.status !== want_line.status)
                    report_mismatch("status", 64'(result_data.status),
                                    64'(want_line.status));
            end
        end
    end

    // Main sequence.
    initial
    begin
        clear_line();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_plain_lines();
        test_timestamps();
        test_frame_ids();
        test_bad_lines();
        test_back_pressure();
        test_steady_stream();
        test_random_lines();
        char_valid <= 1'b0;
        while (pending_lines.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Watchdog.
    initial
    begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/clp_pkg.sv
rtl/core/clp_front.sv
rtl/core/clp_queue.sv
rtl/core/clp_back.sv
rtl/core/can_log_line_parser.sv
bench/can_log_line_parser_tb.sv
